// ----- sv/cls_pkg.sv -----
`default_nettype none
package cls_pkg;

	localparam int MAX_POINTS    = 1024;
	localparam int MAX_CELLS     = 8192;
	localparam int MAX_PER_CELL  = 8;
	localparam int MAX_NEIGHBORS = 64;
	localparam int NUM_OFFS      = 19;

	localparam int PT_W   = $clog2(MAX_POINTS);
	localparam int CELL_W = $clog2(MAX_CELLS);
	localparam int SLOT_W = $clog2(MAX_PER_CELL);
	localparam int LIST_W = $clog2(MAX_NEIGHBORS);

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_FULL    = 3'd1,
		STAT_OUTSIDE = 3'd2,
		STAT_UNKNOWN = 3'd3,
		STAT_TRUNC   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_ORIGIN_Z  = 3'd2,
		REG_CELL_SIZE = 3'd3,
		REG_CELLS_X   = 3'd4,
		REG_CELLS_Y   = 3'd5,
		REG_CELLS_Z   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [9:0]         query_point;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [9:0] point_number;
		logic [9:0] neighbor_point;
		logic [6:0] neighbor_total;
		logic       last;
	} rsp_t;

	function automatic logic signed [10:0] cell_offset(input logic [4:0] k,
			input logic [4:0] z, input logic [8:0] zy);
		logic signed [10:0] sz;
		logic signed [10:0] szy;
		logic signed [10:0] r;
		sz  = signed'({6'd0, z});
		szy = signed'({2'd0, zy});
		case (k)
			5'd0:    r = 11'sd0;
			5'd1:    r = 11'sd1;
			5'd2:    r = -11'sd1;
			5'd3:    r = 11'sd1 + sz;
			5'd4:    r = 11'sd1 - sz;
			5'd5:    r = -11'sd1 + sz;
			5'd6:    r = -11'sd1 - sz;
			5'd7:    r = 11'sd1 + szy;
			5'd8:    r = 11'sd1 - szy;
			5'd9:    r = -11'sd1 + szy;
			5'd10:   r = -11'sd1 - szy;
			5'd11:   r = sz;
			5'd12:   r = -sz;
			5'd13:   r = sz + szy;
			5'd14:   r = sz - szy;
			5'd15:   r = -sz + szy;
			5'd16:   r = -sz - szy;
			5'd17:   r = szy;
			5'd18:   r = -szy;
			default: r = 11'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/cell_list_neighbor_search.sv -----
// Channel  Signals                       Transfer when
// req      req_valid req_ready req       req_valid && req_ready
// rsp      rsp_valid rsp_ready rsp       rsp_valid && rsp_ready
// cfg      cfg_we cfg_index cfg_data     cfg_we
// Clear writes one fill memory entry per cycle.
// Insert divides each axis in the shift-subtract quotient unit.
// Query visits each of the 19 offsets, reads the bucket members of each offset inside
// the table, up to 64 in all, and then emits each result.
// Reset runs a clearing pass over the fill memory; req_ready is low.
// A stalled rsp holds in the output register; the next req is taken meanwhile.
`default_nettype none
module cell_list_neighbor_search import cls_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire req_t        req,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output rsp_t             rsp,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	typedef enum logic [18:0] {
		S_CLR      = 19'd1 << 0,
		S_IDLE     = 19'd1 << 1,
		S_PREP1    = 19'd1 << 2,
		S_PREP2    = 19'd1 << 3,
		S_DIV_INIT = 19'd1 << 4,
		S_DIV_STEP = 19'd1 << 5,
		S_IDX1     = 19'd1 << 6,
		S_IDX2     = 19'd1 << 7,
		S_IFILL    = 19'd1 << 8,
		S_PCRD     = 19'd1 << 9,
		S_PCW      = 19'd1 << 10,
		S_CELL     = 19'd1 << 11,
		S_FILL     = 19'd1 << 12,
		S_MEM      = 19'd1 << 13,
		S_MEMW     = 19'd1 << 14,
		S_NEXT     = 19'd1 << 15,
		S_ERD      = 19'd1 << 16,
		S_EOUT     = 19'd1 << 17,
		S_RESP     = 19'd1 << 18
	} state_t;

	state_t state_q;

	logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic [30:0]        cell_size_q;
	logic [3:0]         cells_x_q, cells_y_q, cells_z_q;

	logic [3:0]              fill_mem [MAX_CELLS];
	logic [PT_W-1:0]         memb_mem [MAX_CELLS*MAX_PER_CELL];
	logic [CELL_W-1:0]       pc_mem   [MAX_POINTS];
	logic [PT_W-1:0]         list_mem [MAX_NEIGHBORS];
	logic [3:0]              fill_rdata;
	logic [PT_W-1:0]         memb_rdata;
	logic [CELL_W-1:0]       pc_rdata;
	logic [PT_W-1:0]         list_rdata;

	logic [CELL_W-1:0] clr_cnt_q;
	logic              clr_resp_q;
	logic [PT_W:0]     loaded_q;
	req_t              req_q;
	rsp_t              res_q;
	logic [8:0]        yz_q;
	logic [14:0]       tl_q;
	logic [1:0]        axis_q;
	logic [1:0]        bit_q;
	logic [35:0]       rem_q;
	logic [3:0]        qd_q;
	logic [3:0]        q_q [3];
	logic [13:0]       px_q;
	logic [9:0]        py_q;
	logic [CELL_W-1:0] idx_q;
	logic [CELL_W-1:0] base_q;
	logic [CELL_W-1:0] c_q;
	logic [4:0]        k_q;
	logic [3:0]        f_q;
	logic [SLOT_W:0]   m_q;
	logic [6:0]        cnt_q;
	logic [6:0]        e_q;
	logic [2:0]        st_q;

	logic [4:0]         dim_x, dim_y, dim_z;
	logic [30:0]        cs_eff;
	logic signed [31:0] p_sel, o_sel;
	logic [3:0]         lim_sel;
	logic signed [32:0] diff;
	logic [35:0]        cs16;
	logic [35:0]        csb;
	logic               take;
	logic [3:0]         qd_n;
	logic [13:0]        idx_w;
	logic signed [14:0] c_w;
	logic               c_ok;
	logic [CELL_W-1:0]  fill_raddr;
	logic               rsp_free;

	assign dim_x  = {1'b0, cells_x_q} + 5'd2;
	assign dim_y  = {1'b0, cells_y_q} + 5'd2;
	assign dim_z  = {1'b0, cells_z_q} + 5'd2;
	assign cs_eff = (cell_size_q == '0) ? 31'd1 : cell_size_q;
	assign cs16   = {1'b0, cs_eff, 4'd0};
	assign csb    = {5'd0, cs_eff} << bit_q;
	assign take   = rem_q >= csb;

	always_comb begin
		qd_n = qd_q;
		if (take) begin
			qd_n[bit_q] = 1'b1;
		end
	end

	always_comb begin
		case (axis_q)
			2'd0:    begin p_sel = req_q.pos_x; o_sel = origin_x_q; lim_sel = cells_x_q; end
			2'd1:    begin p_sel = req_q.pos_y; o_sel = origin_y_q; lim_sel = cells_y_q; end
			default: begin p_sel = req_q.pos_z; o_sel = origin_z_q; lim_sel = cells_z_q; end
		endcase
	end

	assign diff  = {p_sel[31], p_sel} - {o_sel[31], o_sel};
	assign idx_w = px_q + {4'd0, py_q} + {10'd0, q_q[2]} + 14'd1;
	assign c_w   = signed'({2'b00, base_q}) + 15'(cell_offset(k_q, dim_z, yz_q));
	assign c_ok  = !c_w[14] && (15'(c_w) < tl_q) && (15'(c_w) < 15'(MAX_CELLS));
	assign fill_raddr = (state_q == S_CELL) ? c_w[CELL_W-1:0] : idx_w[CELL_W-1:0];
	assign rsp_free   = !rsp_valid || rsp_ready;
	assign req_ready  = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		fill_rdata <= fill_mem[fill_raddr];
		memb_rdata <= memb_mem[{c_q, m_q[SLOT_W-1:0]}];
		pc_rdata   <= pc_mem[req_q.query_point];
		list_rdata <= list_mem[e_q[LIST_W-1:0]];
		if (state_q == S_CLR) begin
			fill_mem[clr_cnt_q] <= 4'd0;
		end else if (state_q == S_IFILL && fill_rdata < 4'(MAX_PER_CELL)) begin
			fill_mem[idx_q] <= fill_rdata + 4'd1;
		end
		if (state_q == S_IFILL && fill_rdata < 4'(MAX_PER_CELL)) begin
			memb_mem[{idx_q, fill_rdata[SLOT_W-1:0]}] <= loaded_q[PT_W-1:0];
			pc_mem[loaded_q[PT_W-1:0]] <= idx_q;
		end
		if (state_q == S_MEMW) begin
			list_mem[cnt_q[LIST_W-1:0]] <= memb_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			origin_z_q  <= '0;
			cell_size_q <= 31'd65536;
			cells_x_q   <= 4'd10;
			cells_y_q   <= 4'd10;
			cells_z_q   <= 4'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X:  origin_x_q  <= signed'(cfg_data);
				REG_ORIGIN_Y:  origin_y_q  <= signed'(cfg_data);
				REG_ORIGIN_Z:  origin_z_q  <= signed'(cfg_data);
				REG_CELL_SIZE: cell_size_q <= cfg_data[30:0];
				REG_CELLS_X:   cells_x_q   <= cfg_data[3:0];
				REG_CELLS_Y:   cells_y_q   <= cfg_data[3:0];
				REG_CELLS_Z:   cells_z_q   <= cfg_data[3:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if ((state_q == S_RESP || state_q == S_EOUT) && rsp_free) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_free) begin
			if (state_q == S_RESP) begin
				rsp <= res_q;
			end else if (state_q == S_EOUT) begin
				rsp.status         <= st_q;
				rsp.point_number   <= req_q.query_point;
				rsp.neighbor_point <= list_rdata;
				rsp.neighbor_total <= cnt_q;
				rsp.last           <= (e_q + 7'd1 == cnt_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_cnt_q  <= '0;
			clr_resp_q <= 1'b0;
			loaded_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == CELL_W'(MAX_CELLS - 1)) begin
						state_q <= clr_resp_q ? S_RESP : S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_PREP1;
					end
				end
				S_PREP1: begin
					yz_q    <= {4'd0, dim_y} * {4'd0, dim_z};
					state_q <= S_PREP2;
				end
				S_PREP2: begin
					tl_q   <= ({10'd0, dim_x} * {6'd0, yz_q}) + {6'd0, yz_q} + {10'd0, dim_z};
					res_q.neighbor_point <= '0;
					res_q.neighbor_total <= '0;
					res_q.last           <= 1'b1;
					axis_q <= 2'd0;
					case (req_q.func)
						FUNC_CLEAR: begin
							res_q.status       <= STAT_OK;
							res_q.point_number <= '0;
							loaded_q   <= '0;
							clr_cnt_q  <= '0;
							clr_resp_q <= 1'b1;
							state_q    <= S_CLR;
						end
						FUNC_INSERT: begin
							res_q.point_number <= loaded_q[PT_W-1:0];
							if (loaded_q >= (PT_W+1)'(MAX_POINTS)) begin
								res_q.status <= STAT_FULL;
								state_q      <= S_RESP;
							end else begin
								res_q.status <= STAT_OK;
								state_q      <= S_DIV_INIT;
							end
						end
						FUNC_QUERY: begin
							res_q.point_number <= req_q.query_point;
							if ({1'b0, req_q.query_point} >= loaded_q) begin
								res_q.status <= STAT_UNKNOWN;
								state_q      <= S_RESP;
							end else begin
								res_q.status <= STAT_OK;
								state_q      <= S_PCRD;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_DIV_INIT: begin
					rem_q <= {3'd0, diff};
					qd_q  <= '0;
					bit_q <= 2'd3;
					if (diff[32] || {3'd0, diff} >= cs16) begin
						res_q.status <= STAT_OUTSIDE;
						state_q      <= S_RESP;
					end else begin
						state_q <= S_DIV_STEP;
					end
				end
				S_DIV_STEP: begin
					if (take) begin
						rem_q <= rem_q - csb;
					end
					qd_q  <= qd_n;
					bit_q <= bit_q - 2'd1;
					if (bit_q == 2'd0) begin
						q_q[axis_q] <= qd_n;
						if (qd_n > lim_sel) begin
							res_q.status <= STAT_OUTSIDE;
							state_q      <= S_RESP;
						end else if (axis_q == 2'd2) begin
							state_q <= S_IDX1;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_DIV_INIT;
						end
					end
				end
				S_IDX1: begin
					px_q    <= ({10'd0, q_q[0]} + 14'd1) * {5'd0, yz_q};
					py_q    <= ({6'd0, q_q[1]} + 10'd1) * {5'd0, dim_z};
					state_q <= S_IDX2;
				end
				S_IDX2: begin
					idx_q <= idx_w[CELL_W-1:0];
					if (idx_w >= 14'(MAX_CELLS)) begin
						res_q.status <= STAT_OUTSIDE;
						state_q      <= S_RESP;
					end else begin
						state_q <= S_IFILL;
					end
				end
				S_IFILL: begin
					if (fill_rdata >= 4'(MAX_PER_CELL)) begin
						res_q.status <= STAT_FULL;
					end else begin
						loaded_q <= loaded_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				S_PCRD: begin
					state_q <= S_PCW;
				end
				S_PCW: begin
					base_q  <= pc_rdata;
					k_q     <= '0;
					cnt_q   <= '0;
					st_q    <= STAT_OK;
					state_q <= S_CELL;
				end
				S_CELL: begin
					c_q     <= c_w[CELL_W-1:0];
					state_q <= c_ok ? S_FILL : S_NEXT;
				end
				S_FILL: begin
					f_q     <= (fill_rdata > 4'(MAX_PER_CELL)) ? 4'(MAX_PER_CELL) : fill_rdata;
					m_q     <= '0;
					state_q <= (fill_rdata == 4'd0) ? S_NEXT : S_MEM;
				end
				S_MEM: begin
					if (cnt_q == 7'(MAX_NEIGHBORS)) begin
						st_q    <= STAT_TRUNC;
						state_q <= S_NEXT;
					end else begin
						state_q <= S_MEMW;
					end
				end
				S_MEMW: begin
					cnt_q <= cnt_q + 7'd1;
					m_q   <= m_q + 1'b1;
					if (4'(m_q) + 4'd1 == f_q) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_MEM;
					end
				end
				S_NEXT: begin
					if (k_q == 5'(NUM_OFFS - 1)) begin
						e_q <= '0;
						if (cnt_q == 7'd0) begin
							res_q.status <= st_q;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_ERD;
						end
					end else begin
						k_q     <= k_q + 5'd1;
						state_q <= S_CELL;
					end
				end
				S_ERD: begin
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (rsp_free) begin
						if (e_q + 7'd1 == cnt_q) begin
							state_q <= S_IDLE;
						end else begin
							e_q     <= e_q + 7'd1;
							state_q <= S_ERD;
						end
					end
				end
				S_RESP: begin
					clr_resp_q <= 1'b0;
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/cls_checker.sv -----
`default_nettype none
module cls_checker import cls_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_UNKNOWN |-> rsp.last && rsp.neighbor_total == 7'd0)
		else $error("unknown point result malformed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.neighbor_total == 7'd0 |-> rsp.last && rsp.neighbor_point == '0)
		else $error("empty result malformed");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.neighbor_total <= 7'(MAX_NEIGHBORS))
		else $error("neighbor total too large");

endmodule

bind cell_list_neighbor_search cls_checker u_cls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire
